// ===== rtl/pls_pkg.sv =====
`default_nettype none

package pls_pkg;

    // radius and colour widths are fixed by the register map
    localparam int RAD_W   = 20;
    localparam int SQ_W    = 2 * RAD_W;
    localparam int CHAN_W  = 8;
    localparam int DSQ_W   = 2 * CHAN_W;
    localparam int T_W     = SQ_W + DSQ_W;
    localparam int Q_W     = SQ_W + CHAN_W;
    localparam int CFG_W   = 20;
    localparam int IDX_W   = 3;

    // pipeline depth ahead of the output register
    localparam int STAGES  = 13;
    localparam int SEARCH0 = 4;

    typedef enum logic [IDX_W-1:0] {
        REG_LIGHT_X     = 3'd0,
        REG_LIGHT_Y     = 3'd1,
        REG_RADIUS      = 3'd2,
        REG_RED         = 3'd3,
        REG_GREEN       = 3'd4,
        REG_BLUE        = 3'd5,
        REG_ISOMETRIC   = 3'd6,
        REG_ENABLE      = 3'd7
    } pls_reg_t;

    typedef struct packed {
        logic            lit;
        logic [SQ_W-1:0] sq;
        logic [SQ_W-1:0] r2;
    } pls_geom_t;

    typedef struct packed {
        logic              lit;
        logic [CHAN_W-1:0] chan;
    } pls_lane_out_t;

endpackage

`default_nettype wire

// ===== rtl/pls_front.sv =====
`default_nettype none

module pls_front #(
    parameter int COORD_BITS = 20
) (
    input  wire logic                              clk,
    input  wire logic [pls_pkg::STAGES:0]          adv,
    input  wire logic signed [COORD_BITS-1:0]      point_x,
    input  wire logic signed [COORD_BITS-1:0]      point_y,
    input  wire logic signed [COORD_BITS-1:0]      light_x,
    input  wire logic signed [COORD_BITS-1:0]      light_y,
    input  wire logic [pls_pkg::RAD_W-1:0]         light_radius,
    input  wire logic                              isometric_shape,
    input  wire logic                              light_enabled,
    output pls_pkg::pls_geom_t                     geom
);

    localparam int CMP_W = (COORD_BITS + 1 > pls_pkg::RAD_W) ? COORD_BITS + 1
                                                              : pls_pkg::RAD_W;

    logic signed [COORD_BITS:0]    dx;
    logic signed [COORD_BITS:0]    dy;
    logic [COORD_BITS-1:0]         adx;
    logic [COORD_BITS-1:0]         ady;
    logic [CMP_W-1:0]              adx_ext;
    logic [CMP_W-1:0]              ey_ext;
    logic [CMP_W-1:0]              rad_ext;
    logic                          inbox;

    logic [pls_pkg::RAD_W-1:0]     adx_reg;
    logic [pls_pkg::RAD_W-1:0]     ey_reg;
    logic                          inbox_reg;
    logic [pls_pkg::SQ_W-1:0]      ax2_reg;
    logic [pls_pkg::SQ_W-1:0]      ey2_reg;
    logic [pls_pkg::SQ_W-1:0]      r2a_reg;
    logic                          inbox1_reg;
    logic [pls_pkg::SQ_W:0]        sq_sum;
    pls_pkg::pls_geom_t            geom_reg;

    always_comb
    begin
        dx      = {light_x[COORD_BITS-1], light_x} - {point_x[COORD_BITS-1], point_x};
        dy      = {light_y[COORD_BITS-1], light_y} - {point_y[COORD_BITS-1], point_y};
        adx     = dx[COORD_BITS] ? COORD_BITS'(-dx) : COORD_BITS'(dx);
        ady     = dy[COORD_BITS] ? COORD_BITS'(-dy) : COORD_BITS'(dy);
        adx_ext = CMP_W'(adx);
        ey_ext  = isometric_shape ? (CMP_W'(ady) << 1) : CMP_W'(ady);
        rad_ext = CMP_W'(light_radius);
        inbox   = light_enabled && (light_radius != '0)
                  && (adx_ext <= rad_ext) && (ey_ext <= rad_ext);
    end

    // box test bounds both offsets by the radius, so they fit its width
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            adx_reg   <= pls_pkg::RAD_W'(adx_ext);
            ey_reg    <= pls_pkg::RAD_W'(ey_ext);
            inbox_reg <= inbox;
        end
        if (adv[1])
        begin
            ax2_reg    <= adx_reg * adx_reg;
            ey2_reg    <= ey_reg * ey_reg;
            r2a_reg    <= light_radius * light_radius;
            inbox1_reg <= inbox_reg;
        end
        if (adv[2])
        begin
            geom_reg.lit <= inbox1_reg && (sq_sum <= {1'b0, r2a_reg});
            geom_reg.sq  <= pls_pkg::SQ_W'(sq_sum);
            geom_reg.r2  <= r2a_reg;
        end
    end

    assign sq_sum = {1'b0, ax2_reg} + {1'b0, ey2_reg};
    assign geom   = geom_reg;

endmodule

`default_nettype wire

// ===== rtl/pls_lane.sv =====
`default_nettype none

module pls_lane (
    input  wire logic                          clk,
    input  wire logic [pls_pkg::STAGES:0]      adv,
    input  wire logic [pls_pkg::CHAN_W-1:0]    light_chan,
    input  wire logic [pls_pkg::CHAN_W-1:0]    base_chan,
    input  wire logic [pls_pkg::CHAN_W-1:0]    vertex_chan,
    input  wire pls_pkg::pls_geom_t            geom,
    output pls_pkg::pls_lane_out_t             result
);

    localparam int CW = pls_pkg::CHAN_W;

    logic [CW-1:0]              bc_reg [0:2];
    logic [CW-1:0]              vc_reg [0:2];
    logic [CW-1:0]              d_reg;
    logic [pls_pkg::DSQ_W-1:0]  d2_reg [1:2];
    logic [CW-1:0]              d_abs;

    // search carries: index 0 is the product stage, 1..8 the search steps
    logic [pls_pkg::T_W-1:0]    t_reg   [0:8];
    logic [pls_pkg::SQ_W-1:0]   r2_reg  [0:8];
    logic                       lit_reg [0:8];
    logic [CW-1:0]              lbc_reg [0:8];
    logic [CW-1:0]              lvc_reg [0:8];
    logic [pls_pkg::T_W-1:0]    p_reg   [1:8];
    logic [pls_pkg::Q_W-1:0]    q_reg   [1:8];
    logic [CW-1:0]              j_reg   [1:8];

    logic [CW:0]                k;
    logic [CW:0]                lc_ext;
    logic [CW-1:0]              fall;
    pls_pkg::pls_lane_out_t     result_reg;

    assign d_abs = (light_chan > base_chan) ? light_chan - base_chan
                                            : base_chan - light_chan;

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            bc_reg[0] <= base_chan;
            vc_reg[0] <= vertex_chan;
            d_reg     <= d_abs;
        end
        if (adv[1])
        begin
            bc_reg[1] <= bc_reg[0];
            vc_reg[1] <= vc_reg[0];
            d2_reg[1] <= d_reg * d_reg;
        end
        if (adv[2])
        begin
            bc_reg[2] <= bc_reg[1];
            vc_reg[2] <= vc_reg[1];
            d2_reg[2] <= d2_reg[1];
        end
        if (adv[3])
        begin
            t_reg[0]   <= geom.sq * d2_reg[2];
            r2_reg[0]  <= geom.r2;
            lit_reg[0] <= geom.lit;
            lbc_reg[0] <= bc_reg[2];
            lvc_reg[0] <= vc_reg[2];
        end
    end

    // one bit of the quotient per step: largest j with j*j*r2 below t
    for (genvar s = 0; s < 8; s++)
    begin : g_step
        localparam int B = 7 - s;
        logic [pls_pkg::T_W-1:0] p_cur;
        logic [pls_pkg::Q_W-1:0] q_cur;
        logic [CW-1:0]           j_cur;
        logic [pls_pkg::T_W+1:0] cand;
        logic                    take;

        if (s == 0)
        begin : g_first
            assign p_cur = '0;
            assign q_cur = '0;
            assign j_cur = '0;
        end
        else
        begin : g_next
            assign p_cur = p_reg[s];
            assign q_cur = q_reg[s];
            assign j_cur = j_reg[s];
        end

        assign cand = (pls_pkg::T_W+2)'(p_cur)
                      + ((pls_pkg::T_W+2)'(q_cur) << (B + 1))
                      + ((pls_pkg::T_W+2)'(r2_reg[s]) << (2 * B));
        assign take = cand < (pls_pkg::T_W+2)'(t_reg[s]);

        always_ff @(posedge clk)
        begin
            if (adv[pls_pkg::SEARCH0 + s])
            begin
                p_reg[s+1]   <= take ? pls_pkg::T_W'(cand) : p_cur;
                q_reg[s+1]   <= take ? q_cur + (pls_pkg::Q_W'(r2_reg[s]) << B) : q_cur;
                j_reg[s+1]   <= take ? (j_cur | CW'(1 << B)) : j_cur;
                t_reg[s+1]   <= t_reg[s];
                r2_reg[s+1]  <= r2_reg[s];
                lit_reg[s+1] <= lit_reg[s];
                lbc_reg[s+1] <= lbc_reg[s];
                lvc_reg[s+1] <= lvc_reg[s];
            end
        end
    end

    // ceiling step is one above the largest j, none when nothing is subtracted
    always_comb
    begin
        k      = (t_reg[8] != '0) ? {1'b0, j_reg[8]} + (CW+1)'(1) : '0;
        lc_ext = {1'b0, light_chan};
        fall   = (lc_ext >= k) ? CW'(lc_ext - k) : '0;
    end

    always_ff @(posedge clk)
    begin
        if (adv[12])
        begin
            result_reg.lit  <= lit_reg[8];
            if (lit_reg[8])
            begin
                result_reg.chan <= (fall < lvc_reg[8]) ? lvc_reg[8] : fall;
            end
            else
            begin
                result_reg.chan <= lbc_reg[8];
            end
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

// ===== rtl/point_light_vertex_shade.sv =====
`default_nettype none

// channel  | handshake            | beat contents
// ---------+----------------------+-------------------------------------------
// vertex   | in_valid / in_ready  | point_x, point_y, vertex_rgb, base_rgb
// shade    | out_valid / out_ready| out_red, out_green, out_blue, within_light
// config   | cfg_write            | cfg_index, cfg_data, no wait
//
// one vertex beat per cycle while the output is not stalled
// pipeline depth is set mostly by the eight-step bit search for the falloff step in each colour lane
// reset clears pipeline valids and loads the light defaults, no clearing pass
// a stalled output only holds the beats that cannot move; bubbles close up behind it

module point_light_vertex_shade #(
    parameter int COORD_BITS = 20
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic signed [COORD_BITS-1:0]      point_x,
    input  wire logic signed [COORD_BITS-1:0]      point_y,
    input  wire logic [7:0]                        vertex_red,
    input  wire logic [7:0]                        vertex_green,
    input  wire logic [7:0]                        vertex_blue,
    input  wire logic [7:0]                        base_red,
    input  wire logic [7:0]                        base_green,
    input  wire logic [7:0]                        base_blue,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [7:0]                             out_red,
    output logic [7:0]                             out_green,
    output logic [7:0]                             out_blue,
    output logic                                   within_light,
    input  wire logic                              cfg_write,
    input  wire logic [pls_pkg::IDX_W-1:0]         cfg_index,
    // write data as wide as the widest register
    input  wire logic [(COORD_BITS > pls_pkg::RAD_W ? COORD_BITS
                                                    : pls_pkg::RAD_W)-1:0] cfg_data
);

    localparam int N = pls_pkg::STAGES;

    // light registers
    logic signed [COORD_BITS-1:0]  light_x_reg;
    logic signed [COORD_BITS-1:0]  light_y_reg;
    logic [pls_pkg::RAD_W-1:0]     radius_reg;
    logic [7:0]                    red_reg;
    logic [7:0]                    green_reg;
    logic [7:0]                    blue_reg;
    logic                          iso_reg;
    logic                          enable_reg;

    // one valid per stage, the last one is the output register
    logic [N:0]                    v_reg;
    logic [N:0]                    v_next;
    logic [N:0]                    adv;

    pls_pkg::pls_geom_t            geom;
    pls_pkg::pls_lane_out_t        res_r;
    pls_pkg::pls_lane_out_t        res_g;
    pls_pkg::pls_lane_out_t        res_b;

    logic [7:0]                    out_red_reg;
    logic [7:0]                    out_green_reg;
    logic [7:0]                    out_blue_reg;
    logic                          within_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_x_reg <= '0;
            light_y_reg <= '0;
            radius_reg  <= pls_pkg::RAD_W'(16);
            red_reg     <= 8'hff;
            green_reg   <= 8'hff;
            blue_reg    <= 8'hff;
            iso_reg     <= 1'b0;
            enable_reg  <= 1'b1;
        end
        else if (cfg_write)
        begin
            unique case (pls_pkg::pls_reg_t'(cfg_index))
                pls_pkg::REG_LIGHT_X:   light_x_reg <= COORD_BITS'(cfg_data);
                pls_pkg::REG_LIGHT_Y:   light_y_reg <= COORD_BITS'(cfg_data);
                pls_pkg::REG_RADIUS:    radius_reg  <= pls_pkg::RAD_W'(cfg_data);
                pls_pkg::REG_RED:       red_reg     <= cfg_data[7:0];
                pls_pkg::REG_GREEN:     green_reg   <= cfg_data[7:0];
                pls_pkg::REG_BLUE:      blue_reg    <= cfg_data[7:0];
                pls_pkg::REG_ISOMETRIC: iso_reg     <= cfg_data[0];
                pls_pkg::REG_ENABLE:    enable_reg  <= cfg_data[0];
                default:                ;
            endcase
        end
    end

    // a stage may load when it is empty or its contents move on
    always_comb
    begin
        adv[N] = !v_reg[N] || out_ready;
        for (int i = N - 1; i >= 0; i--)
        begin
            adv[i] = !v_reg[i] || adv[i+1];
        end
        v_next[0] = adv[0] ? in_valid : v_reg[0];
        for (int i = 1; i <= N; i++)
        begin
            v_next[i] = adv[i] ? v_reg[i-1] : v_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    // distance and radius test, shared by the three colour lanes
    pls_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk             (clk),
        .adv             (adv),
        .point_x         (point_x),
        .point_y         (point_y),
        .light_x         (light_x_reg),
        .light_y         (light_y_reg),
        .light_radius    (radius_reg),
        .isometric_shape (iso_reg),
        .light_enabled   (enable_reg),
        .geom            (geom)
    );

    pls_lane u_lane_r (
        .clk         (clk),
        .adv         (adv),
        .light_chan  (red_reg),
        .base_chan   (base_red),
        .vertex_chan (vertex_red),
        .geom        (geom),
        .result      (res_r)
    );

    pls_lane u_lane_g (
        .clk         (clk),
        .adv         (adv),
        .light_chan  (green_reg),
        .base_chan   (base_green),
        .vertex_chan (vertex_green),
        .geom        (geom),
        .result      (res_g)
    );

    pls_lane u_lane_b (
        .clk         (clk),
        .adv         (adv),
        .light_chan  (blue_reg),
        .base_chan   (base_blue),
        .vertex_chan (vertex_blue),
        .geom        (geom),
        .result      (res_b)
    );

    // merge the lanes into the output register
    always_ff @(posedge clk)
    begin
        if (adv[N])
        begin
            out_red_reg   <= res_r.chan;
            out_green_reg <= res_g.chan;
            out_blue_reg  <= res_b.chan;
            within_reg    <= res_r.lit;
        end
    end

    assign in_ready     = adv[0];
    assign out_valid    = v_reg[N];
    assign out_red      = out_red_reg;
    assign out_green    = out_green_reg;
    assign out_blue     = out_blue_reg;
    assign within_light = within_reg;

endmodule

`default_nettype wire

// ===== rtl/pls_checker.sv =====
`default_nettype none

module pls_checker (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_ready,
    input  wire logic       out_valid,
    input  wire logic       out_ready,
    input  wire logic [7:0] out_red,
    input  wire logic [7:0] out_green,
    input  wire logic [7:0] out_blue,
    input  wire logic       within_light
);

    // input is refused only when the whole pipe is blocked by the output
    a_refuse_only_when_blocked: assert property (
        @(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input refused without an output stall");

    // nothing comes out straight after reset
    a_quiet_after_reset: assert property (
        @(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("output beat right after reset");

    a_stall_holds: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_red)
            && $stable(out_green) && $stable(out_blue) && $stable(within_light)))
        else $error("stalled output beat changed");

endmodule

bind point_light_vertex_shade pls_checker u_pls_checker (.*);

`default_nettype wire

// ===== dv/tb_point_light_vertex_shade.sv =====
`default_nettype none

module tb_point_light_vertex_shade;

    localparam int CW        = 20;
    localparam int N_RANDOM  = 1030;
    localparam int WD_LIMIT  = 5000;
    localparam int DRAIN_CYC = 40;
    localparam int HOLD_CYC  = 300;

    // one vertex beat as offered to the block
    typedef struct {
        logic signed [CW-1:0] px;
        logic signed [CW-1:0] py;
        logic [7:0]           vr, vg, vb;
        logic [7:0]           br, bg, bb;
    } vertex_t;

    // one shaded result
    typedef struct {
        logic [7:0] r, g, b;
        logic       lit;
    } shade_t;

    // light settings kept alongside the block's registers
    typedef struct {
        logic signed [CW-1:0] lx;
        logic signed [CW-1:0] ly;
        logic [19:0]          rad;
        logic [7:0]           lr, lg, lb;
        logic                 iso;
        logic                 en;
    } light_t;

    // exact integer square root, floor
    function automatic longint unsigned isqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    // one colour lane of the linear falloff
    function automatic logic [7:0] falloff_chan(logic [7:0] lc, logic [7:0] bc,
                                                logic [7:0] vc, longint unsigned sq,
                                                longint unsigned rad);
        longint unsigned d, t, m, k, v;
        d = (lc > bc) ? lc - bc : bc - lc;
        t = sq * d * d;
        m = isqrt(t);
        if (m * m < t)
            m++;
        k = (m + rad - 1) / rad;
        v = (lc >= k) ? lc - k : 0;
        if (v < vc)
            v = vc;
        return v[7:0];
    endfunction

    function automatic shade_t shade_vertex(light_t L, vertex_t p);
        longint signed   dxs, dys;
        longint unsigned adx, ady, ey, sq, rad;
        shade_t s;
        dxs = longint'(L.lx) - longint'(p.px);
        dys = longint'(L.ly) - longint'(p.py);
        adx = (dxs < 0) ? -dxs : dxs;
        ady = (dys < 0) ? -dys : dys;
        ey  = L.iso ? 2 * ady : ady;
        rad = L.rad;
        s.lit = 1'b0;
        sq = 0;
        if (L.en && rad != 0 && adx <= rad && ey <= rad)
        begin
            sq = adx * adx + ey * ey;
            s.lit = (sq <= rad * rad);
        end
        if (s.lit)
        begin
            s.r = falloff_chan(L.lr, p.br, p.vr, sq, rad);
            s.g = falloff_chan(L.lg, p.bg, p.vg, sq, rad);
            s.b = falloff_chan(L.lb, p.bb, p.vb, sq, rad);
        end
        else
        begin
            s.r = p.br;
            s.g = p.bg;
            s.b = p.bb;
        end
        return s;
    endfunction

    // holds expected shades in beat order and checks each output beat
    class shade_board;
        shade_t pending[$];
        int     errors;
        int     checked;
        int     lit_seen;

        function void note_vertex(light_t L, vertex_t p);
            pending.push_back(shade_vertex(L, p));
        endfunction

        function void check_shade(shade_t got);
            shade_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected shade beat r=%0d g=%0d b=%0d lit=%0b",
                         $time, got.r, got.g, got.b, got.lit);
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.lit)
                lit_seen++;
            if (got.r !== want.r)
            begin
                $display("%0t: out_red exp %0d got %0d", $time, want.r, got.r);
                errors++;
            end
            if (got.g !== want.g)
            begin
                $display("%0t: out_green exp %0d got %0d", $time, want.g, got.g);
                errors++;
            end
            if (got.b !== want.b)
            begin
                $display("%0t: out_blue exp %0d got %0d", $time, want.b, got.b);
                errors++;
            end
            if (got.lit !== want.lit)
            begin
                $display("%0t: within_light exp %0b got %0b", $time, want.lit, got.lit);
                errors++;
            end
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_ready;
    logic signed [CW-1:0]          point_x;
    logic signed [CW-1:0]          point_y;
    logic [7:0]                    vertex_red, vertex_green, vertex_blue;
    logic [7:0]                    base_red, base_green, base_blue;
    logic                          out_valid;
    logic                          out_ready;
    logic [7:0]                    out_red, out_green, out_blue;
    logic                          within_light;
    logic                          cfg_write;
    logic [pls_pkg::IDX_W-1:0]     cfg_index;
    logic [pls_pkg::CFG_W-1:0]     cfg_data;

    shade_board board;
    light_t     light;
    int         idle_cycles;
    int         beats_in;
    bit         hold_req;    // stimulus asks the receiver for one long hold-off
    bit         hold_done;   // receiver has served that hold-off

    point_light_vertex_shade u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .point_x      (point_x),
        .point_y      (point_y),
        .vertex_red   (vertex_red),
        .vertex_green (vertex_green),
        .vertex_blue  (vertex_blue),
        .base_red     (base_red),
        .base_green   (base_green),
        .base_blue    (base_blue),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_red      (out_red),
        .out_green    (out_green),
        .out_blue     (out_blue),
        .within_light (within_light),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // 10 unit clock
    initial
        clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        point_x      = '0;
        point_y      = '0;
        vertex_red   = '0;
        vertex_green = '0;
        vertex_blue  = '0;
        base_red     = '0;
        base_green   = '0;
        base_blue    = '0;
        out_ready    = 1'b0;
        cfg_write    = 1'b0;
        cfg_index    = pls_pkg::REG_LIGHT_X;
        cfg_data     = '0;
    end

    // register write, cfg_write dropped again before the task returns, mirrored in the local light copy
    task automatic write_reg(pls_pkg::pls_reg_t idx, logic [pls_pkg::CFG_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            pls_pkg::REG_LIGHT_X:   light.lx  = val;
            pls_pkg::REG_LIGHT_Y:   light.ly  = val;
            pls_pkg::REG_RADIUS:    light.rad = val;
            pls_pkg::REG_RED:       light.lr  = val[7:0];
            pls_pkg::REG_GREEN:     light.lg  = val[7:0];
            pls_pkg::REG_BLUE:      light.lb  = val[7:0];
            pls_pkg::REG_ISOMETRIC: light.iso = val[0];
            pls_pkg::REG_ENABLE:    light.en  = val[0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_light(light_t L);
        write_reg(pls_pkg::REG_LIGHT_X, L.lx);
        write_reg(pls_pkg::REG_LIGHT_Y, L.ly);
        write_reg(pls_pkg::REG_RADIUS, L.rad);
        write_reg(pls_pkg::REG_RED, 20'(L.lr));
        write_reg(pls_pkg::REG_GREEN, 20'(L.lg));
        write_reg(pls_pkg::REG_BLUE, 20'(L.lb));
        write_reg(pls_pkg::REG_ISOMETRIC, 20'(L.iso));
        write_reg(pls_pkg::REG_ENABLE, 20'(L.en));
    endtask

    // offer one vertex beat after a random gap, hold it until taken
    task automatic send_vertex(vertex_t p, bit no_gap);
        int gap;
        gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15));
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap)
                @(posedge clk);
        end
        in_valid     <= 1'b1;
        point_x      <= p.px;
        point_y      <= p.py;
        vertex_red   <= p.vr;
        vertex_green <= p.vg;
        vertex_blue  <= p.vb;
        base_red     <= p.br;
        base_green   <= p.bg;
        base_blue    <= p.bb;
        do
            @(posedge clk);
        while (!in_ready);
        board.note_vertex(light, p);
        beats_in++;
    endtask

    // stop offering and pause until the block has returned every shade
    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC)
            @(posedge clk);
    endtask

    function automatic vertex_t rand_colours(vertex_t p);
        p.vr = $urandom; p.vg = $urandom; p.vb = $urandom;
        p.br = $urandom; p.bg = $urandom; p.bb = $urandom;
        // dark vertex colours often, so the falloff itself shows through
        if ($urandom_range(0, 2) != 0)
        begin
            p.vr = $urandom_range(0, 30);
            p.vg = $urandom_range(0, 30);
            p.vb = $urandom_range(0, 30);
        end
        return p;
    endfunction

    // vertex near the light mostly, anywhere sometimes
    function automatic vertex_t rand_vertex();
        vertex_t p;
        longint  span;
        longint  ox, oy;
        p = rand_colours(p);
        span = longint'(light.rad) + 2;
        if ($urandom_range(0, 7) == 0)
        begin
            p.px = $urandom;
            p.py = $urandom;
        end
        else
        begin
            ox = longint'($urandom_range(0, 2 * span)) - span;
            oy = longint'($urandom_range(0, 2 * span)) - span;
            if (light.iso)
                oy = oy / 2;
            p.px = CW'(longint'(light.lx) + ox);
            p.py = CW'(longint'(light.ly) + oy);
        end
        return p;
    endfunction

    function automatic vertex_t make_vertex(longint x, longint y,
                                            logic [7:0] v, logic [7:0] b);
        vertex_t p;
        p.px = CW'(x); p.py = CW'(y);
        p.vr = v; p.vg = v; p.vb = v;
        p.br = b; p.bg = b; p.bb = b;
        return p;
    endfunction

    function automatic light_t rand_light();
        light_t L;
        int     pick;
        L.lx = $urandom;
        L.ly = $urandom;
        pick = $urandom_range(0, 9);
        // small radii mostly, the widest ones a few times
        if (pick < 6)
            L.rad = $urandom_range(1, 400);
        else if (pick < 9)
            L.rad = $urandom_range(1, 20'hFFFFF);
        else
            L.rad = (pick & 1) ? 20'hFFFFF : 20'd1;
        L.lr = $urandom; L.lg = $urandom; L.lb = $urandom;
        L.iso = $urandom;
        L.en  = ($urandom_range(0, 5) != 0);
        return L;
    endfunction

    // receiver: random stalls, and one long hold-off counted here when asked
    initial
    begin : shade_sink
        int stall;
        hold_done = 0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req && !hold_done)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYC)
                    @(posedge clk);
                hold_done = 1;
            end
            else
            begin
                stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
                if (stall != 0)
                begin
                    out_ready <= 1'b0;
                    repeat (stall)
                        @(posedge clk);
                end
                out_ready <= 1'b1;
                do
                    @(posedge clk);
                while (!out_valid);
            end
        end
    end

    // output beats are taken where valid and ready meet at the edge
    always @(posedge clk)
    begin
        shade_t s;
        if (rst_n && out_valid && out_ready)
        begin
            s.r = out_red; s.g = out_green; s.b = out_blue; s.lit = within_light;
            board.check_shade(s);
        end
    end

    // watchdog on cycles with no beat either side
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT)
        begin
            $display("%0t: watchdog, no progress", $time);
            $display("tb_point_light_vertex_shade failed");
            $finish;
        end
    end

    initial
    begin
        light_t  L;
        vertex_t p;
        board       = new();
        idle_cycles = 0;
        beats_in    = 0;
        hold_req    = 0;
        light.lx = '0; light.ly = '0; light.rad = 20'd16;
        light.lr = 8'd255; light.lg = 8'd255; light.lb = 8'd255;
        light.iso = 1'b0; light.en = 1'b1;

        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults: centre, on the radius, just outside, vertex colour above the falloff
        send_vertex(make_vertex(0, 0, 0, 0), 0);
        send_vertex(make_vertex(16, 0, 0, 100), 0);
        send_vertex(make_vertex(0, -16, 7, 255), 0);
        send_vertex(make_vertex(17, 0, 0, 50), 0);
        send_vertex(make_vertex(8, 8, 200, 10), 0);
        drain();

        // isometric shape, light at the negative corner, light colours zero, half and full
        L.lx = 20'sh80000; L.ly = 20'sh80000; L.rad = 20'd64;
        L.lr = 8'd0; L.lg = 8'd128; L.lb = 8'd255; L.iso = 1'b1; L.en = 1'b1;
        set_light(L);
        send_vertex(make_vertex(-524288 + 64, -524288, 0, 255), 0);
        send_vertex(make_vertex(-524288, -524288 + 32, 0, 0), 0);
        send_vertex(make_vertex(-524288, -524288 + 33, 0, 0), 0);
        send_vertex(make_vertex(-524288 + 30, -524288 + 20, 255, 40), 0);
        send_vertex(make_vertex(524287, 524287, 255, 3), 0);
        drain();

        // widest radius from the positive corner, then the smallest radius
        L.lx = 20'sh7FFFF; L.ly = 20'sh7FFFF; L.rad = 20'hFFFFF;
        L.lr = 8'd255; L.lg = 8'd1; L.lb = 8'd170; L.iso = 1'b0;
        set_light(L);
        send_vertex(make_vertex(-524288, -524288, 0, 0), 0);
        send_vertex(make_vertex(-524288, 524287, 0, 255), 0);
        send_vertex(make_vertex(0, 0, 255, 85), 0);
        drain();
        write_reg(pls_pkg::REG_RADIUS, 20'd1);
        send_vertex(make_vertex(524286, 524287, 0, 0), 0);
        send_vertex(make_vertex(524286, 524286, 0, 0), 0);
        drain();

        // light disabled: base colour passes through even at the centre
        write_reg(pls_pkg::REG_ENABLE, 20'd0);
        send_vertex(make_vertex(524287, 524287, 255, 17), 0);
        send_vertex(make_vertex(0, 0, 0, 200), 0);
        drain();

        // random phases with fresh settings between them
        for (int ph = 0; ph < 10; ph++)
        begin
            set_light(rand_light());
            for (int i = 0; i < N_RANDOM / 10; i++)
            begin
                p = rand_vertex();
                // partway through one phase: ask for a long receiver hold and
                // keep offering back to back so the pipeline fills and stalls
                if (ph == 3 && i == 20)
                    hold_req = 1;
                send_vertex(p, (ph == 3) && (i >= 20) && (i < 60));
            end
            drain();
        end

        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC)
            @(posedge clk);

        $display("%0d vertex beats in, %0d shades checked, %0d lit by the light",
                 beats_in, board.checked, board.lit_seen);
        $display("covered both shapes, enable off, corner positions, radius 1 and full");
        if (board.errors == 0 && board.pending.size() == 0)
            $display("tb_point_light_vertex_shade passed");
        else
            $display("tb_point_light_vertex_shade failed");
        $finish;
    end

endmodule

`default_nettype wire
